// ===== design/gde_pkg.sv =====
// ----------------------------------------------------------------------------
// gde_pkg: shared types, constants and helpers
// Payload structs, the internal work record, fixed-point constants, the
// exponent and arctangent tables, and rounding/saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package gde_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int EXP_STEPS = 16;
	localparam int ITER_STAGES = (CORDIC_STAGES > EXP_STEPS) ? CORDIC_STAGES : EXP_STEPS;
	localparam int STAGE_IDX_W = 5;

	localparam logic [7:0] REG_AMPLITUDE = 8'd0;
	localparam logic [7:0] REG_SIGMA     = 8'd1;
	localparam logic [7:0] REG_FREQUENCY = 8'd2;
	localparam logic [7:0] REG_PHASE     = 8'd3;

	localparam logic [31:0] AMPLITUDE_RST = 32'd655360;
	localparam logic [30:0] SIGMA_RST     = 31'd13107;
	localparam logic [31:0] FREQUENCY_RST = 32'd6554;
	localparam logic [18:0] PHASE_RST     = 19'd0;

	localparam logic [30:0] ONE_Q30     = 31'd1073741824;
	localparam logic [30:0] INV_LN2_Q30 = 31'd1549082005;
	localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;
	localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0] sample_x;
		logic               last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] model_value;
		logic signed [31:0] deriv_amplitude;
		logic signed [31:0] deriv_sigma;
		logic signed [31:0] deriv_frequency;
		logic signed [31:0] deriv_phase;
		logic               last_out;
	} out_item_t;

	// Record that travels down the iterative section.
	typedef struct packed {
		logic               last;
		logic signed [31:0] x;
		logic [33:0]        w;
		logic               big;
		logic [20:0]        y;
		logic [30:0]        p;
		logic signed [33:0] cx;
		logic signed [33:0] cy;
		logic signed [33:0] z;
		logic               flip;
	} work_t;

	// Factors 2^-(2^-(j+1)) in Q30.
	function automatic logic [29:0] exp_factor(input logic [STAGE_IDX_W-1:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:    v = 30'd759250125;
			5'd1:    v = 30'd902905651;
			5'd2:    v = 30'd984625594;
			5'd3:    v = 30'd1028218693;
			5'd4:    v = 30'd1050733751;
			5'd5:    v = 30'd1062175491;
			5'd6:    v = 30'd1067942999;
			5'd7:    v = 30'd1070838486;
			5'd8:    v = 30'd1072289173;
			5'd9:    v = 30'd1073015252;
			5'd10:   v = 30'd1073378477;
			5'd11:   v = 30'd1073560135;
			5'd12:   v = 30'd1073650976;
			5'd13:   v = 30'd1073696399;
			5'd14:   v = 30'd1073719111;
			5'd15:   v = 30'd1073730468;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	// atan(2^-i) in turns, 32 fraction bits.
	function automatic logic [29:0] atan_turn(input logic [STAGE_IDX_W-1:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:    v = 30'd536870912;
			5'd1:    v = 30'd316933406;
			5'd2:    v = 30'd167458907;
			5'd3:    v = 30'd85004756;
			5'd4:    v = 30'd42667331;
			5'd5:    v = 30'd21354465;
			5'd6:    v = 30'd10679838;
			5'd7:    v = 30'd5340245;
			5'd8:    v = 30'd2670163;
			5'd9:    v = 30'd1335087;
			5'd10:   v = 30'd667544;
			5'd11:   v = 30'd333772;
			5'd12:   v = 30'd166886;
			5'd13:   v = 30'd83443;
			5'd14:   v = 30'd41722;
			5'd15:   v = 30'd20861;
			5'd16:   v = 30'd10430;
			5'd17:   v = 30'd5215;
			5'd18:   v = 30'd2608;
			5'd19:   v = 30'd1304;
			5'd20:   v = 30'd652;
			5'd21:   v = 30'd326;
			5'd22:   v = 30'd163;
			5'd23:   v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	// Magnitude divided by 2^s, rounded half up (half away from zero on magnitudes).
	function automatic logic [79:0] round_mag(input logic [79:0] p, input logic [6:0] s);
		return (p + (80'd1 << (s - 7'd1))) >> s;
	endfunction

	// Sign and magnitude to a saturated 32-bit two's complement value.
	function automatic logic [31:0] sat_q(input logic neg, input logic [79:0] m);
		logic [31:0] r;
		if (!neg) begin
			r = (m > 80'd2147483647) ? 32'h7FFF_FFFF : m[31:0];
		end else begin
			r = (m > 80'd2147483648) ? 32'h8000_0000 : (32'd0 - m[31:0]);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/gaussian_damped_oscillation_eval.sv =====
// ----------------------------------------------------------------------------
// gaussian_damped_oscillation_eval: gaussian-damped cosine with Jacobian
// Streams samples x and returns A*exp(-(G*x)^2)*cos(2*pi*f*x+phi) together
// with its partial derivatives by A, G, f and phi, all in Q16.16.
// ----------------------------------------------------------------------------
// The block accepts one sample per clock while the output is not stalled
// and returns exactly one result per sample, in order. A request enters on
// in_valid/in_ready and leaves on out_valid/out_ready; the pipeline moves
// as a whole whenever the output register is empty or being taken, so a
// stalled consumer holds every stage and nothing is lost or repeated. Four
// stages prepare the decay argument and the angle, ITER_STAGES stages each
// do one exponent-table multiply and one CORDIC rotation, and six stages
// apply the exponent shift, form the products with the amplitude and
// saturate. Throughput is one sample per cycle when not stalled. The
// exponential becomes zero once |G*x| exceeds 4.0, and then every output
// but last_out is zero. The four registers (amplitude, decay_sigma,
// frequency, phase) are written through cfg_valid/cfg_index/cfg_data; the
// user must write them only while the pipeline is empty, which the block
// itself does not enforce. cfg_ready is always high; unknown indexes are
// dropped. Phase is used as written, with no wrap into minus pi to pi.
// ----------------------------------------------------------------------------
`default_nettype none
module gaussian_damped_oscillation_eval import gde_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire in_item_t    in_data,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      out_item_t   out_data,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [31:0] amplitude_q;
	logic [30:0] sigma_q;
	logic [31:0] frequency_q;
	logic [18:0] phase_q;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= AMPLITUDE_RST;
			sigma_q     <= SIGMA_RST;
			frequency_q <= FREQUENCY_RST;
			phase_q     <= PHASE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_AMPLITUDE: amplitude_q <= cfg_data;
				REG_SIGMA:     sigma_q     <= cfg_data[30:0];
				REG_FREQUENCY: frequency_q <= cfg_data;
				REG_PHASE:     phase_q     <= cfg_data[18:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless a finished result is waiting and not being taken.
	logic en;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic  valid_chain [0:ITER_STAGES];
	work_t work_chain  [0:ITER_STAGES];

	gde_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_i   (in_valid),
		.item_i    (in_data),
		.sigma     (sigma_q),
		.frequency (frequency_q),
		.phase     (phase_q),
		.valid_o   (valid_chain[0]),
		.work_o    (work_chain[0])
	);

	for (genvar j = 0; j < ITER_STAGES; j++) begin : g_iter
		gde_iter u_iter (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.stage_idx (STAGE_IDX_W'(j)),
			.valid_i   (valid_chain[j]),
			.work_i    (work_chain[j]),
			.valid_o   (valid_chain[j+1]),
			.work_o    (work_chain[j+1])
		);
	end

	gde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_i   (valid_chain[ITER_STAGES]),
		.work_i    (work_chain[ITER_STAGES]),
		.amplitude (amplitude_q),
		.valid_o   (out_valid),
		.item_o    (out_data)
	);

endmodule
`default_nettype wire

// ===== design/gde_front.sv =====
// ----------------------------------------------------------------------------
// gde_front: argument preparation
// Four stages: decay argument t, exponent e/ln2, angle in turns and the
// CORDIC quadrant fold, and the product t*|x| used by the sigma derivative.
// ----------------------------------------------------------------------------
`default_nettype none
module gde_front import gde_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        valid_i,
	input  wire in_item_t    item_i,
	input  wire logic [30:0] sigma,
	input  wire logic [31:0] frequency,
	input  wire logic [18:0] phase,
	output      logic        valid_o,
	output      work_t       work_o
);

	logic        valid_s1, valid_s2, valid_s3;
	logic signed [31:0] x_s1, x_s2, x_s3;
	logic        last_s1, last_s2, last_s3;
	logic [31:0] ux_s1;
	logic [62:0] st_s1;
	logic [31:0] fx_s1;
	logic [48:0] pt_s1;
	logic        phi_neg_s1;

	logic [31:0] ux_c;
	logic [18:0] phi_mag_c;
	logic [31:0] fx_c;

	assign ux_c      = item_i.sample_x[31] ? (32'd0 - item_i.sample_x) : item_i.sample_x;
	assign phi_mag_c = phase[18] ? (19'd0 - phase) : phase;
	assign fx_c      = frequency * item_i.sample_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_o  <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_o  <= valid_s3;
		end
	end

	// Stage 1: the three input products.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1       <= item_i.sample_x;
			last_s1    <= item_i.last_in;
			ux_s1      <= ux_c;
			st_s1      <= sigma * ux_c;
			fx_s1      <= fx_c;
			pt_s1      <= phi_mag_c * INV_2PI_Q32;
			phi_neg_s1 <= phase[18];
		end
	end

	// Stage 2: t, turns and the fold into the right half plane.
	logic [62:0] t_sum;
	logic [46:0] t_full;
	logic [18:0] t19;
	logic        big_c;
	logic [48:0] pt_sum;
	logic [31:0] pt_mag, pt_val, turns;
	logic signed [33:0] z0, z_c;
	logic        flip_c;

	assign t_sum  = st_s1 + 63'd32768;
	assign t_full = t_sum[62:16];
	assign t19    = t_full[18:0];
	assign big_c  = t_full > 47'd262144;
	assign pt_sum = pt_s1 + 49'd32768;
	assign pt_mag = pt_sum[47:16];
	assign pt_val = phi_neg_s1 ? (32'd0 - pt_mag) : pt_mag;
	assign turns  = fx_s1 + pt_val;
	assign z0     = {{2{turns[31]}}, turns};

	always_comb begin
		z_c    = z0;
		flip_c = 1'b0;
		if (z0 > 34'sd1073741824) begin
			z_c    = z0 - 34'sd2147483648;
			flip_c = 1'b1;
		end else if (z0 < -34'sd1073741824) begin
			z_c    = z0 + 34'sd2147483648;
			flip_c = 1'b1;
		end
	end

	logic [37:0] tt_s2;
	logic [50:0] tw_s2;
	logic        big_s2, big_s3;
	logic signed [33:0] z_s2, z_s3;
	logic        flip_s2, flip_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= x_s1;
			last_s2 <= last_s1;
			tt_s2   <= t19 * t19;
			tw_s2   <= t19 * ux_s1;
			big_s2  <= big_c;
			z_s2    <= z_c;
			flip_s2 <= flip_c;
		end
	end

	// Stage 3: e = t^2 and W = t*|x|, then e/ln2.
	logic [37:0] tt_sum;
	logic [50:0] tw_sum;
	logic [20:0] e_c;
	logic [51:0] ey_s3;
	logic [33:0] w_s3;

	assign tt_sum = tt_s2 + 38'd32768;
	assign tw_sum = tw_s2 + 51'd32768;
	assign e_c    = tt_sum[36:16];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3    <= x_s2;
			last_s3 <= last_s2;
			ey_s3   <= e_c * INV_LN2_Q30;
			w_s3    <= tw_sum[49:16];
			big_s3  <= big_s2;
			z_s3    <= z_s2;
			flip_s3 <= flip_s2;
		end
	end

	// Stage 4: y in Q16.16 and the start values of the iterative section.
	logic [51:0] ey_sum;

	assign ey_sum = ey_s3 + 52'd536870912;

	always_ff @(posedge clk) begin
		if (en) begin
			work_o.last <= last_s3;
			work_o.x    <= x_s3;
			work_o.w    <= w_s3;
			work_o.big  <= big_s3;
			work_o.y    <= ey_sum[50:30];
			work_o.p    <= ONE_Q30;
			work_o.cx   <= CORDIC_GAIN_Q30;
			work_o.cy   <= 34'sd0;
			work_o.z    <= z_s3;
			work_o.flip <= flip_s3;
		end
	end

endmodule
`default_nettype wire

// ===== design/gde_iter.sv =====
// ----------------------------------------------------------------------------
// gde_iter: one iterative stage
// One conditional exponent-table multiply and one CORDIC rotation step,
// selected by the stage index, followed by the stage register.
// ----------------------------------------------------------------------------
`default_nettype none
module gde_iter import gde_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic [STAGE_IDX_W-1:0] stage_idx,
	input  wire logic                   valid_i,
	input  wire work_t                  work_i,
	output      logic                   valid_o,
	output      work_t                  work_o
);

	logic [3:0]  bit_pos;
	logic        use_exp, use_rot;
	logic [60:0] prod, prod_sum;
	logic signed [33:0] cx, cy, z, dx, dy, ang;
	work_t       nxt;

	assign bit_pos  = 4'd15 - stage_idx[3:0];
	assign use_exp  = (stage_idx < 5'(EXP_STEPS)) && work_i.y[bit_pos];
	assign use_rot  = stage_idx < 5'(CORDIC_STAGES);
	assign prod     = work_i.p * exp_factor(stage_idx);
	assign prod_sum = prod + 61'd536870912;
	assign cx       = work_i.cx;
	assign cy       = work_i.cy;
	assign z        = work_i.z;
	assign dx       = cy >>> stage_idx;
	assign dy       = cx >>> stage_idx;
	assign ang      = $signed({4'd0, atan_turn(stage_idx)});

	always_comb begin
		nxt = work_i;
		if (use_exp) begin
			nxt.p = prod_sum[60:30];
		end
		if (use_rot) begin
			if (z >= 34'sd0) begin
				nxt.cx = cx - dx;
				nxt.cy = cy + dy;
				nxt.z  = z - ang;
			end else begin
				nxt.cx = cx + dx;
				nxt.cy = cy - dy;
				nxt.z  = z + ang;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_o <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== design/gde_back.sv =====
// ----------------------------------------------------------------------------
// gde_back: products and output formatting
// Applies the exponent shift, forms g*cos and g*sin, scales by the
// amplitude, builds the four derivatives and saturates into Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none
module gde_back import gde_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        valid_i,
	input  wire work_t       work_i,
	input  wire logic [31:0] amplitude,
	output      logic        valid_o,
	output      out_item_t   item_o
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_o  <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_o  <= valid_s5;
		end
	end

	// Stage 1: integer part of the exponent as a rounded right shift.
	logic [4:0]  k;
	logic [31:0] g_sum;
	logic [30:0] g_c;
	logic signed [33:0] cx_f, cy_f;

	assign k     = work_i.y[20:16];
	assign g_sum = {1'b0, work_i.p} + (32'd1 << (k - 5'd1));
	assign cx_f  = work_i.flip ? -work_i.cx : work_i.cx;
	assign cy_f  = work_i.flip ? -work_i.cy : work_i.cy;

	always_comb begin
		if (work_i.big || k == 5'd31) begin
			g_c = 31'd0;
		end else if (k == 5'd0) begin
			g_c = work_i.p;
		end else begin
			g_c = 31'(g_sum >> k);
		end
	end

	logic [30:0] g_s1;
	logic signed [33:0] cx_s1, cy_s1;
	logic signed [31:0] x_s1, x_s2, x_s3;
	logic [33:0] w_s1, w_s2, w_s3;
	logic        last_s1, last_s2, last_s3, last_s4, last_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1    <= g_c;
			cx_s1   <= cx_f;
			cy_s1   <= cy_f;
			x_s1    <= work_i.x;
			w_s1    <= work_i.w;
			last_s1 <= work_i.last;
		end
	end

	// Stage 2: g times cosine and sine.
	logic [33:0] cx_mag, cy_mag;
	logic [64:0] gcx_s2, gcy_s2;
	logic        cx_neg_s2, cy_neg_s2;

	assign cx_mag = cx_s1[33] ? (34'd0 - cx_s1) : cx_s1;
	assign cy_mag = cy_s1[33] ? (34'd0 - cy_s1) : cy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			gcx_s2    <= g_s1 * cx_mag;
			gcy_s2    <= g_s1 * cy_mag;
			cx_neg_s2 <= cx_s1[33];
			cy_neg_s2 <= cy_s1[33];
			x_s2      <= x_s1;
			w_s2      <= w_s1;
			last_s2   <= last_s1;
		end
	end

	// Stage 3: round gc and gs, scale both by the amplitude.
	logic [79:0] gc_r, gs_r;
	logic [31:0] a_mag;
	logic [64:0] am_s3, as_s3;
	logic        m_neg_s3, ps_neg_s3;
	logic [31:0] d_amp_s3, d_amp_s4, d_amp_s5;

	assign gc_r  = round_mag(80'(gcx_s2), 7'd30);
	assign gs_r  = round_mag(80'(gcy_s2), 7'd30);
	assign a_mag = amplitude[31] ? (32'd0 - amplitude) : amplitude;

	always_ff @(posedge clk) begin
		if (en) begin
			am_s3     <= a_mag * gc_r[32:0];
			as_s3     <= a_mag * gs_r[32:0];
			m_neg_s3  <= amplitude[31] ^ cx_neg_s2;
			ps_neg_s3 <= amplitude[31] ^ cy_neg_s2;
			d_amp_s3  <= sat_q(cx_neg_s2, round_mag(80'(gc_r[32:0]), 7'd14));
			x_s3      <= x_s2;
			w_s3      <= w_s2;
			last_s3   <= last_s2;
		end
	end

	// Stage 4: M and P, then W*M and P*x.
	logic [79:0] m_r, ps_r;
	logic [31:0] ux3;
	logic [68:0] wm_s4;
	logic [66:0] px_s4;
	logic        m_neg_s4, r_neg_s4;
	logic [31:0] val_s4, val_s5, d_ph_s4, d_ph_s5;

	assign m_r  = round_mag(80'(am_s3), 7'd30);
	assign ps_r = round_mag(80'(as_s3), 7'd30);
	assign ux3  = x_s3[31] ? (32'd0 - x_s3) : x_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			wm_s4    <= w_s3 * m_r[34:0];
			px_s4    <= ps_r[34:0] * ux3;
			m_neg_s4 <= m_neg_s3;
			r_neg_s4 <= ps_neg_s3 ^ x_s3[31];
			val_s4   <= sat_q(m_neg_s3, m_r);
			d_ph_s4  <= sat_q(!ps_neg_s3, ps_r);
			d_amp_s4 <= d_amp_s3;
			last_s4  <= last_s3;
		end
	end

	// Stage 5: R, held to 2^30 since anything above saturates the last step.
	logic [79:0] r_r;
	logic [30:0] r_clamp;
	logic [62:0] rp_s5;
	logic        r_neg_s5;
	logic [31:0] d_sig_s5;

	assign r_r     = round_mag(80'(px_s4), 7'd16);
	assign r_clamp = (r_r > 80'd1073741824) ? 31'd1073741824 : r_r[30:0];

	always_ff @(posedge clk) begin
		if (en) begin
			rp_s5    <= r_clamp * TWO_PI_Q29;
			r_neg_s5 <= r_neg_s4;
			d_sig_s5 <= sat_q(!m_neg_s4, round_mag(80'(wm_s4), 7'd15));
			val_s5   <= val_s4;
			d_ph_s5  <= d_ph_s4;
			d_amp_s5 <= d_amp_s4;
			last_s5  <= last_s4;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			item_o.model_value     <= val_s5;
			item_o.deriv_amplitude <= d_amp_s5;
			item_o.deriv_sigma     <= d_sig_s5;
			item_o.deriv_frequency <= sat_q(!r_neg_s5, round_mag(80'(rp_s5), 7'd29));
			item_o.deriv_phase     <= d_ph_s5;
			item_o.last_out        <= last_s5;
		end
	end

endmodule
`default_nettype wire
